>>> hw/rtl/i2c_bit_level_master_core_defines.svh
// Assertion macros shared by the bit-level I2C master RTL.
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define I2CBM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define I2CBM_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/i2cbm_pkg.sv
// Shared types and constants for the bit-level I2C master.
// No dependencies; imported by i2c_bit_level_master_core and tb_top.
`default_nettype none

package i2cbm_pkg;

	// Default width of the phase tick counter and the phase length register.
	localparam int DelayWidthDefault = 16;

	// Field widths of the streaming items and the configuration word.
	localparam int ActionWidth = 3;
	localparam int ByteWidth   = 8;
	localparam int StatusWidth = 2;
	localparam int CfgWidth    = 16;
	localparam int InDataWidth  = 16;
	localparam int OutDataWidth = 16;

	// Command codes carried in the action field.
	localparam logic [ActionWidth-1:0] ACT_NONE      = 3'd0;
	localparam logic [ActionWidth-1:0] ACT_START     = 3'd1;
	localparam logic [ActionWidth-1:0] ACT_STOP      = 3'd2;
	localparam logic [ActionWidth-1:0] ACT_WRITE     = 3'd3;
	localparam logic [ActionWidth-1:0] ACT_READ_ACK  = 3'd4;
	localparam logic [ActionWidth-1:0] ACT_READ_NACK = 3'd5;

	// Result codes of the last start condition.
	localparam logic [StatusWidth-1:0] STAT_READY    = 2'd0;
	localparam logic [StatusWidth-1:0] STAT_BUS_BUSY = 2'd1;
	localparam logic [StatusWidth-1:0] STAT_BUS_ERR  = 2'd2;

	// Bit counter width and the number of data bits in a byte.
	localparam int BitCntWidth = 4;
	localparam logic [BitCntWidth-1:0] BITS_PER_BYTE = 4'd8;

	// Bus phases, one-hot.
	typedef enum logic [17:0] {
		PH_IDLE        = 18'h00001,
		PH_ST_SDA_HI   = 18'h00002,
		PH_ST_SCL_HI   = 18'h00004,
		PH_ST_SDA_LO   = 18'h00008,
		PH_ST_SCL_LO   = 18'h00010,
		PH_SP_SDA_LO   = 18'h00020,
		PH_SP_SCL_HI   = 18'h00040,
		PH_SP_SDA_HI   = 18'h00080,
		PH_WR_DATA     = 18'h00100,
		PH_WR_HI       = 18'h00200,
		PH_WR_LO       = 18'h00400,
		PH_WR_ACK_REL  = 18'h00800,
		PH_WR_ACK_HI   = 18'h01000,
		PH_RD_HI       = 18'h02000,
		PH_RD_LO       = 18'h04000,
		PH_RD_ACK_DATA = 18'h08000,
		PH_RD_ACK_HI   = 18'h10000,
		PH_RD_ACK_LO   = 18'h20000
	} phase_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2c_bit_level_master_core.sv
// Bit-level I2C master sequencer, top level.
// Depends on i2cbm_pkg and i2c_bit_level_master_core_defines.svh.
//
// Usage:
//   Each input item on s_* is one tick of the bus sequencer. It carries a
//   command code, the byte to write and the sampled SDA level. Every accepted
//   item produces exactly one result item on m_* with the SCL level, the SDA
//   pull-down, busy and done flags, the last received byte, the ACK flag and
//   the last start status.
//   The result of an item is registered and valid in the cycle after it is
//   accepted. Throughput is one item per cycle while the receiver takes
//   results; the whole update is one pass through the phase decoder between
//   the state registers and the output register.
//   s_tready is high while the output register is empty or being taken, so a
//   stalled receiver holds the pending result and pauses the input side; the
//   bus state only advances on accepted items.
//   Commands arriving while a command is in progress are ignored.
//   cfg_wr_en writes the phase length in ticks (0 acts as 1); write it only
//   while no command is running.
//   Reset leaves the sequencer idle with SCL high, SDA released, a phase
//   length of one tick and no result pending.
`default_nettype none

`include "i2c_bit_level_master_core_defines.svh"

module i2c_bit_level_master_core
	import i2cbm_pkg::*;
#(
	parameter int DELAY_WIDTH = DelayWidthDefault
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Input items: action [2:0], tx_byte [10:3], sda_in [11], zero [15:12].
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [InDataWidth-1:0]  s_tdata,
	// Result items: scl_level [0], sda_pull_low [1], busy_res [2], done_res [3],
	// rx_byte [11:4], ack_seen [12], start_status [14:13], zero [15].
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [OutDataWidth-1:0]      m_tdata,
	// Phase length register.
	input  wire logic                    cfg_wr_en,
	input  wire logic [CfgWidth-1:0]     cfg_wr_data
);

	// Unpacked input fields.
	logic [ActionWidth-1:0] in_action;
	logic [ByteWidth-1:0]   in_tx_byte;
	logic                   in_sda;
	logic                   in_acc;

	assign in_action  = s_tdata[ActionWidth-1:0];
	assign in_tx_byte = s_tdata[ActionWidth+ByteWidth-1:ActionWidth];
	assign in_sda     = s_tdata[ActionWidth+ByteWidth];
	assign in_acc     = s_tvalid && s_tready;

	// Sequencer state.
	phase_t                 phase_q;
	logic [BitCntWidth-1:0] bit_q;
	logic [ByteWidth-1:0]   shift_q;
	logic [DELAY_WIDTH-1:0] tick_q;
	logic [ActionWidth-1:0] cmd_q;
	logic                   scl_q;
	logic                   sda_q;
	logic                   ack_q;
	logic [StatusWidth-1:0] status_q;
	logic [ByteWidth-1:0]   rx_q;
	logic [DELAY_WIDTH-1:0] ticks_q;

	// Output register.
	logic                    m_tvalid_q;
	logic [OutDataWidth-1:0] m_tdata_q;

	// Next-state values.
	phase_t                 phase_n;
	logic [BitCntWidth-1:0] bit_n;
	logic [BitCntWidth-1:0] bit_inc;
	logic [ByteWidth-1:0]   shift_n;
	logic [ByteWidth-1:0]   shift_e;
	logic [DELAY_WIDTH-1:0] tick_n;
	logic [DELAY_WIDTH-1:0] tick_inc;
	logic [DELAY_WIDTH-1:0] limit;
	logic [ActionWidth-1:0] cmd_n;
	logic                   scl_n;
	logic                   scl_e;
	logic                   sda_n;
	logic                   sda_e;
	logic                   ack_n;
	logic [StatusWidth-1:0] status_n;
	logic [ByteWidth-1:0]   rx_n;
	logic                   done_n;
	logic                   busy_n;
	logic                   enter;
	logic                   phase_end;
	logic [31:0]            cfg_wide;

	// A zero phase length behaves as one tick.
	assign limit    = (ticks_q == '0) ? DELAY_WIDTH'(1) : ticks_q;
	assign tick_inc = tick_q + DELAY_WIDTH'(1);
	assign phase_end = (tick_inc >= limit) || (tick_inc == '0);
	assign bit_inc  = bit_q + BitCntWidth'(1);
	assign cfg_wide = {{(32 - CfgWidth){1'b0}}, cfg_wr_data};

	// Command start and phase completion.
	always_comb begin
		phase_n  = phase_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		tick_n   = tick_q;
		cmd_n    = cmd_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		ack_n    = ack_q;
		status_n = status_q;
		rx_n     = rx_q;
		done_n   = 1'b0;
		enter    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (in_action >= ACT_START && in_action <= ACT_READ_NACK) begin
				cmd_n  = in_action;
				bit_n  = '0;
				tick_n = '0;
				enter  = 1'b1;
				case (in_action)
					ACT_START: begin
						phase_n = PH_ST_SDA_HI;
					end
					ACT_STOP: begin
						phase_n = PH_SP_SDA_LO;
					end
					ACT_WRITE: begin
						shift_n = in_tx_byte;
						phase_n = PH_WR_DATA;
					end
					default: begin
						shift_n = '0;
						sda_n   = 1'b0;
						phase_n = PH_RD_HI;
					end
				endcase
			end
		end else begin
			tick_n = tick_inc;
			if (phase_end) begin
				tick_n = '0;
				enter  = 1'b1;
				case (phase_q)
					PH_ST_SDA_HI: begin
						phase_n = PH_ST_SCL_HI;
					end
					PH_ST_SCL_HI: begin
						// SDA held low by another master: the bus is taken.
						if (!in_sda) begin
							status_n = STAT_BUS_BUSY;
							done_n   = 1'b1;
						end else begin
							phase_n = PH_ST_SDA_LO;
						end
					end
					PH_ST_SDA_LO: begin
						phase_n = PH_ST_SCL_LO;
					end
					PH_ST_SCL_LO: begin
						status_n = in_sda ? STAT_BUS_ERR : STAT_READY;
						done_n   = 1'b1;
					end
					PH_SP_SDA_LO: begin
						phase_n = PH_SP_SCL_HI;
					end
					PH_SP_SCL_HI: begin
						phase_n = PH_SP_SDA_HI;
					end
					PH_SP_SDA_HI: begin
						done_n = 1'b1;
					end
					PH_WR_DATA: begin
						phase_n = PH_WR_HI;
					end
					PH_WR_HI: begin
						phase_n = PH_WR_LO;
					end
					PH_WR_LO: begin
						bit_n   = bit_inc;
						phase_n = (bit_inc >= BITS_PER_BYTE) ? PH_WR_ACK_REL : PH_WR_DATA;
					end
					PH_WR_ACK_REL: begin
						phase_n = PH_WR_ACK_HI;
					end
					PH_WR_ACK_HI: begin
						ack_n  = !in_sda;
						scl_n  = 1'b0;
						done_n = 1'b1;
					end
					PH_RD_HI: begin
						shift_n = {shift_q[ByteWidth-2:0], in_sda};
						phase_n = PH_RD_LO;
					end
					PH_RD_LO: begin
						bit_n   = bit_inc;
						phase_n = (bit_inc >= BITS_PER_BYTE) ? PH_RD_ACK_DATA : PH_RD_HI;
					end
					PH_RD_ACK_DATA: begin
						phase_n = PH_RD_ACK_HI;
					end
					PH_RD_ACK_HI: begin
						phase_n = PH_RD_ACK_LO;
					end
					PH_RD_ACK_LO: begin
						rx_n   = shift_q;
						done_n = 1'b1;
					end
					default: begin
						// Unknown phase: drop back to idle without a done pulse.
						enter   = 1'b0;
						phase_n = PH_IDLE;
					end
				endcase
				if (done_n) begin
					enter   = 1'b0;
					phase_n = PH_IDLE;
				end
			end
		end
	end

	// Line levels applied on entry to the next phase.
	always_comb begin
		scl_e   = scl_n;
		sda_e   = sda_n;
		shift_e = shift_n;
		if (enter) begin
			case (phase_n)
				PH_ST_SDA_HI, PH_SP_SDA_HI, PH_WR_ACK_REL: begin
					sda_e = 1'b0;
				end
				PH_ST_SDA_LO, PH_SP_SDA_LO: begin
					sda_e = 1'b1;
				end
				PH_ST_SCL_HI, PH_SP_SCL_HI, PH_WR_HI, PH_WR_ACK_HI, PH_RD_HI,
				PH_RD_ACK_HI: begin
					scl_e = 1'b1;
				end
				PH_ST_SCL_LO, PH_WR_LO, PH_RD_LO, PH_RD_ACK_LO: begin
					scl_e = 1'b0;
				end
				PH_WR_DATA: begin
					// MSB goes out first; a zero bit pulls SDA low.
					scl_e   = 1'b0;
					sda_e   = !shift_n[ByteWidth-1];
					shift_e = {shift_n[ByteWidth-2:0], 1'b0};
				end
				PH_RD_ACK_DATA: begin
					sda_e = (cmd_n == ACT_READ_ACK);
				end
				default: begin
					sda_e = sda_n;
				end
			endcase
		end
	end

	assign busy_n = (phase_n != PH_IDLE);

	// Sequencer state registers, advanced once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			bit_q    <= '0;
			shift_q  <= '0;
			tick_q   <= '0;
			cmd_q    <= ACT_NONE;
			scl_q    <= 1'b1;
			sda_q    <= 1'b0;
			ack_q    <= 1'b0;
			status_q <= STAT_READY;
			rx_q     <= '0;
		end else if (in_acc) begin
			phase_q  <= phase_n;
			bit_q    <= bit_n;
			shift_q  <= shift_e;
			tick_q   <= tick_n;
			cmd_q    <= cmd_n;
			scl_q    <= scl_e;
			sda_q    <= sda_e;
			ack_q    <= ack_n;
			status_q <= status_n;
			rx_q     <= rx_n;
		end
	end

	// Phase length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= DELAY_WIDTH'(1);
		end else if (cfg_wr_en) begin
			ticks_q <= cfg_wide[DELAY_WIDTH-1:0];
		end
	end

	// Output register: filled on accept, emptied when the receiver takes it.
	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_acc) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_tdata_q <= {1'b0, status_n, ack_n, rx_n, done_n, busy_n, sda_e, scl_e};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Checks on the sequencer.
	`I2CBM_NEVER(a_done_not_busy, m_tvalid_q && m_tdata_q[3] && m_tdata_q[2], "done with busy set")
	`I2CBM_ASSERT(a_bit_count_range, bit_q <= BITS_PER_BYTE, "bit counter past one byte")
	`I2CBM_ASSERT(a_accept_fills_out, in_acc |=> m_tvalid_q, "accepted item produced no result")
	`I2CBM_ASSERT(a_idle_no_done, (in_acc && phase_q == PH_IDLE) |=> !m_tdata_q[3], "done from idle")

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the bit-level I2C master sequencer.
// Drives tick items with shaped SDA samples, predicts every result item in
// its own sequencer copy and compares them; depends on i2cbm_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cbm_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 10;

	// Action codes that carry no command.
	localparam logic [ActionWidth-1:0] ACT_RSVD6 = 3'd6;
	localparam logic [ActionWidth-1:0] ACT_RSVD7 = 3'd7;

	// Number of bus phases of each command.
	localparam int START_PHASES = 4;
	localparam int BUSY_PHASES  = 2;
	localparam int STOP_PHASES  = 3;
	localparam int WRITE_PHASES = 26;
	localparam int READ_PHASES  = 19;

	// One input item, packed from the lowest bit up: action, tx byte, SDA level.
	typedef struct packed {
		logic                 sda;
		logic [ByteWidth-1:0] tx;
		logic [ActionWidth-1:0] act;
	} tick_t;

	// One result item, packed from the lowest bit up as on m_tdata.
	typedef struct packed {
		logic [StatusWidth-1:0] status;
		logic                   ack;
		logic [ByteWidth-1:0]   rx;
		logic                   done;
		logic                   busy;
		logic                   pull;
		logic                   scl;
	} bus_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [InDataWidth-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OutDataWidth-1:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [CfgWidth-1:0] cfg_wr_data = '0;

	// Pending input items and the bus results predicted for accepted items.
	tick_t tick_q[$];
	bus_out_t bus_status_q[$];
	tick_t cur_tick;
	bus_out_t seen_res;
	bus_out_t want_res;

	// Predicted sequencer state.
	phase_t                 seq_ph;
	logic [BitCntWidth-1:0] seq_nbits;
	logic [ByteWidth-1:0]   seq_shift;
	logic [15:0]            seq_tcnt;
	logic [ActionWidth-1:0] seq_kind;
	logic                   seq_scl;
	logic                   seq_pull;
	logic                   seq_ack;
	logic [StatusWidth-1:0] seq_stat;
	logic [ByteWidth-1:0]   seq_rx;
	logic [CfgWidth-1:0]    seq_len;

	// Stimulus bookkeeping and run statistics.
	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int gen_len = 1;
	int gen_count = 0;
	int hold_req_cnt = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int n_bad = 0;
	int n_checked = 0;
	int n_done = 0;
	int n_accepted = 0;
	int unsigned n_cycles = 0;

	i2c_bit_level_master_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #2 clk = ~clk;

	// State of the sequencer right after reset.
	function automatic void seq_reset();
		seq_ph = PH_IDLE;
		seq_nbits = '0;
		seq_shift = '0;
		seq_tcnt = '0;
		seq_kind = ACT_NONE;
		seq_scl = 1'b1;
		seq_pull = 1'b0;
		seq_ack = 1'b0;
		seq_stat = STAT_READY;
		seq_rx = '0;
		seq_len = 16'd1;
	endfunction

	// Enters a phase and applies its line levels.
	function automatic void go_phase(phase_t p);
		seq_ph = p;
		seq_tcnt = '0;
		case (p)
			PH_ST_SDA_HI, PH_SP_SDA_HI, PH_WR_ACK_REL: seq_pull = 1'b0;
			PH_ST_SDA_LO, PH_SP_SDA_LO: seq_pull = 1'b1;
			PH_ST_SCL_HI, PH_SP_SCL_HI, PH_WR_HI, PH_WR_ACK_HI,
			PH_RD_HI, PH_RD_ACK_HI: seq_scl = 1'b1;
			PH_ST_SCL_LO, PH_WR_LO, PH_RD_LO, PH_RD_ACK_LO: seq_scl = 1'b0;
			PH_WR_DATA: begin
				seq_scl = 1'b0;
				seq_pull = ~seq_shift[7];
				seq_shift = {seq_shift[6:0], 1'b0};
			end
			PH_RD_ACK_DATA: seq_pull = (seq_kind == ACT_READ_ACK);
			default: ;
		endcase
	endfunction

	// Ends the current phase with the sampled SDA level; returns 1 when the
	// command is complete.
	function automatic logic finish_phase(logic sda);
		logic fin;
		fin = 1'b0;
		case (seq_ph)
			PH_ST_SDA_HI: go_phase(PH_ST_SCL_HI);
			PH_ST_SCL_HI: begin
				if (!sda) begin
					seq_stat = STAT_BUS_BUSY;
					fin = 1'b1;
				end else begin
					go_phase(PH_ST_SDA_LO);
				end
			end
			PH_ST_SDA_LO: go_phase(PH_ST_SCL_LO);
			PH_ST_SCL_LO: begin
				seq_stat = sda ? STAT_BUS_ERR : STAT_READY;
				fin = 1'b1;
			end
			PH_SP_SDA_LO: go_phase(PH_SP_SCL_HI);
			PH_SP_SCL_HI: go_phase(PH_SP_SDA_HI);
			PH_SP_SDA_HI: fin = 1'b1;
			PH_WR_DATA: go_phase(PH_WR_HI);
			PH_WR_HI: go_phase(PH_WR_LO);
			PH_WR_LO: begin
				seq_nbits = seq_nbits + 1'b1;
				if (seq_nbits >= BITS_PER_BYTE) begin
					go_phase(PH_WR_ACK_REL);
				end else begin
					go_phase(PH_WR_DATA);
				end
			end
			PH_WR_ACK_REL: go_phase(PH_WR_ACK_HI);
			PH_WR_ACK_HI: begin
				seq_ack = ~sda;
				seq_scl = 1'b0;
				fin = 1'b1;
			end
			PH_RD_HI: begin
				seq_shift = {seq_shift[6:0], sda};
				go_phase(PH_RD_LO);
			end
			PH_RD_LO: begin
				seq_nbits = seq_nbits + 1'b1;
				if (seq_nbits >= BITS_PER_BYTE) begin
					go_phase(PH_RD_ACK_DATA);
				end else begin
					go_phase(PH_RD_HI);
				end
			end
			PH_RD_ACK_DATA: go_phase(PH_RD_ACK_HI);
			PH_RD_ACK_HI: go_phase(PH_RD_ACK_LO);
			PH_RD_ACK_LO: begin
				seq_rx = seq_shift;
				fin = 1'b1;
			end
			default: fin = 1'b1;
		endcase
		return fin;
	endfunction

	// Advances the predicted sequencer by one tick and returns the bus result.
	function automatic bus_out_t advance_sequencer(tick_t t);
		bus_out_t r;
		logic [16:0] lim;
		logic fin;
		fin = 1'b0;
		lim = (seq_len == '0) ? 17'd1 : {1'b0, seq_len};
		if (seq_ph == PH_IDLE) begin
			if (t.act >= ACT_START && t.act <= ACT_READ_NACK) begin
				seq_kind = t.act;
				seq_nbits = '0;
				case (t.act)
					ACT_START: go_phase(PH_ST_SDA_HI);
					ACT_STOP: go_phase(PH_SP_SDA_LO);
					ACT_WRITE: begin
						seq_shift = t.tx;
						go_phase(PH_WR_DATA);
					end
					default: begin
						seq_shift = '0;
						seq_pull = 1'b0;
						go_phase(PH_RD_HI);
					end
				endcase
			end
		end else begin
			seq_tcnt = seq_tcnt + 1'b1;
			if ({1'b0, seq_tcnt} >= lim || seq_tcnt == '0) begin
				seq_tcnt = '0;
				if (finish_phase(t.sda)) begin
					seq_ph = PH_IDLE;
					fin = 1'b1;
				end
			end
		end
		r.scl = seq_scl;
		r.pull = seq_pull;
		r.busy = (seq_ph != PH_IDLE);
		r.done = fin;
		r.rx = seq_rx;
		r.ack = seq_ack;
		r.status = seq_stat;
		return r;
	endfunction

	// Sender: offers queued items and predicts each accepted one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) begin
				seq_len = cfg_wr_data;
			end
			if (s_tvalid && s_tready) begin
				bus_status_q.push_back(advance_sequencer(cur_tick));
				n_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					cur_tick = tick_q.pop_front();
					s_tdata <= {{(InDataWidth - $bits(tick_t)){1'b0}}, cur_tick};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen_res = m_tdata[$bits(bus_out_t)-1:0];
				if (bus_status_q.size() == 0) begin
					if (n_bad < MAX_REPORTS) begin
						$display("tb: result item with no prediction waiting: %h", m_tdata);
					end
					n_bad++;
				end else begin
					want_res = bus_status_q.pop_front();
					n_checked++;
					if (want_res.done) begin
						n_done++;
					end
					if (seen_res !== want_res) begin
						if (n_bad < MAX_REPORTS) begin
							$display("tb: result %0d differs", n_checked);
							$display("  expected scl %b pull %b busy %b done %b rx %h ack %b st %0d",
								want_res.scl, want_res.pull, want_res.busy, want_res.done,
								want_res.rx, want_res.ack, want_res.status);
							$display("  actual   scl %b pull %b busy %b done %b rx %h ack %b st %0d",
								seen_res.scl, seen_res.pull, seen_res.busy, seen_res.done,
								seen_res.rx, seen_res.ack, seen_res.status);
						end
						n_bad++;
					end
				end
			end
			m_tready <= (hold_left != 0) ? 1'b0 : ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Long receiver hold-off, started on request and counted down here.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req_cnt) begin
			hold_left <= HOLD_CYCLES;
			hold_seen <= hold_req_cnt;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_tick(logic [ActionWidth-1:0] a, logic [ByteWidth-1:0] b, logic c);
		tick_q.push_back({c, b, a});
		gen_count++;
	endtask

	// Queues a command and the ticks that carry it to its end. The SDA level
	// is chosen on the tick where each phase samples it: for a start, bit 0
	// frees the bus and bit 1 flags an error; for a write, bit 0 is the ACK
	// level; for a read, the byte to return. Other ticks get random SDA and,
	// with noise_pct, random commands that the busy sequencer must ignore.
	// trim shortens the run so the next command lands while still busy.
	task automatic queue_command(logic [ActionWidth-1:0] act, logic [ByteWidth-1:0] tx,
			logic [7:0] smp_bits, int noise_pct, int trim);
		logic smp [WRITE_PHASES];
		int np;
		int span;
		for (int i = 0; i < WRITE_PHASES; i++) begin
			smp[i] = 1'($urandom_range(1));
		end
		case (act)
			ACT_START: begin
				smp[1] = smp_bits[0];
				smp[3] = smp_bits[1];
				np = smp_bits[0] ? START_PHASES : BUSY_PHASES;
			end
			ACT_STOP: np = STOP_PHASES;
			ACT_WRITE: begin
				smp[WRITE_PHASES-1] = smp_bits[0];
				np = WRITE_PHASES;
			end
			ACT_READ_ACK, ACT_READ_NACK: begin
				for (int b = 0; b < 8; b++) begin
					smp[2*b] = smp_bits[7-b];
				end
				np = READ_PHASES;
			end
			default: np = 0;
		endcase
		push_tick(act, tx, 1'($urandom_range(1)));
		span = np * gen_len - trim;
		for (int i = 1; i <= span; i++) begin
			push_tick(($urandom_range(99) < noise_pct) ? 3'($urandom_range(7, 1)) : ACT_NONE,
				8'($urandom_range(255)),
				(i % gen_len == 0) ? smp[i / gen_len - 1] : 1'($urandom_range(1)));
		end
	endtask

	// Mostly well-formed transactions with random content, the rest noise.
	task automatic queue_random_traffic(int n);
		int stop_at;
		logic [7:0] st_bits;
		stop_at = gen_count + n;
		while (gen_count < stop_at) begin
			if ($urandom_range(99) < 85) begin
				st_bits = {6'b0, ($urandom_range(9) == 0), ($urandom_range(9) != 0)};
				queue_command(ACT_START, 8'($urandom_range(255)), st_bits, 3, 0);
				repeat ($urandom_range(3, 1)) begin
					case ($urandom_range(2))
						0: queue_command(ACT_WRITE, 8'($urandom_range(255)),
							{7'b0, ($urandom_range(3) == 0)}, 3, 0);
						1: queue_command(ACT_READ_ACK, 8'($urandom_range(255)),
							8'($urandom_range(255)), 3, 0);
						default: queue_command(ACT_READ_NACK, 8'($urandom_range(255)),
							8'($urandom_range(255)), 3, 0);
					endcase
				end
				queue_command(ACT_STOP, 8'($urandom_range(255)), 8'($urandom_range(255)), 3, 0);
				repeat ($urandom_range(2)) begin
					push_tick(ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
				end
			end else begin
				case ($urandom_range(3))
					0: repeat ($urandom_range(4, 1)) begin
						push_tick(3'($urandom_range(7)), 8'($urandom_range(255)),
							1'($urandom_range(1)));
					end
					1: queue_command(3'($urandom_range(5, 1)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 20, $urandom_range(6, 1));
					2: repeat ($urandom_range(5, 1)) begin
						push_tick(ACT_NONE, 8'($urandom_range(255)), 1'($urandom_range(1)));
					end
					default: push_tick($urandom_range(1) ? ACT_RSVD6 : ACT_RSVD7,
						8'($urandom_range(255)), 1'($urandom_range(1)));
				endcase
			end
		end
	endtask

	// Waits until every item is through and the sequencer has no command
	// running, feeding empty ticks to finish one that is still going. The
	// check runs between edges, so an item taken from the queue at the last
	// edge already shows on s_tvalid; it returns on a rising edge.
	task automatic settle();
		bit quiet;
		quiet = 1'b0;
		while (!quiet) begin
			@(negedge clk);
			if (tick_q.size() == 0 && !s_tvalid && bus_status_q.size() == 0) begin
				if (seq_ph == PH_IDLE) begin
					quiet = 1'b1;
				end else begin
					push_tick(ACT_NONE, 8'h00, 1'b1);
				end
			end
		end
		@(posedge clk);
	endtask

	// Writes the phase length while the sequencer is idle.
	task automatic set_phase_len(logic [CfgWidth-1:0] v);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		gen_len = (v == '0) ? 1 : int'(v);
	endtask

	initial begin
		seq_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Sender idles often, receiver idles most of the time.
		src_idle_pct = 23;
		snk_idle_pct = 64;
		set_phase_len(16'd1);

		// Directed: idle and reserved codes, a clean transfer with byte
		// extremes, ACK and NACK, a busy bus, a bus error, and commands
		// issued while busy and on the finishing tick.
		push_tick(ACT_NONE, 8'h00, 1'b0);
		push_tick(ACT_RSVD6, 8'hFF, 1'b1);
		push_tick(ACT_RSVD7, 8'h00, 1'b0);
		queue_command(ACT_START, 8'h00, 8'h01, 0, 0);
		queue_command(ACT_WRITE, 8'hFF, 8'h00, 0, 0);
		queue_command(ACT_WRITE, 8'h00, 8'h01, 0, 0);
		queue_command(ACT_READ_ACK, 8'h00, 8'hA5, 0, 0);
		queue_command(ACT_READ_NACK, 8'h00, 8'h5A, 0, 0);
		queue_command(ACT_READ_ACK, 8'hFF, 8'hFF, 0, 0);
		queue_command(ACT_READ_NACK, 8'hFF, 8'h00, 0, 0);
		queue_command(ACT_STOP, 8'h00, 8'h00, 0, 0);
		queue_command(ACT_START, 8'h00, 8'h00, 0, 0);
		queue_command(ACT_START, 8'h00, 8'h03, 0, 0);
		queue_command(ACT_WRITE, 8'h81, 8'h00, 100, 0);
		queue_command(ACT_STOP, 8'h00, 8'h00, 100, 0);

		// A zero phase length behaves as one tick.
		set_phase_len(16'd0);
		queue_command(ACT_START, 8'h00, 8'h01, 0, 0);
		queue_command(ACT_STOP, 8'h00, 8'h00, 0, 0);
		queue_random_traffic(250);
		set_phase_len(16'd2);
		queue_random_traffic(300);

		// Roles swapped.
		set_phase_len(16'd3);
		src_idle_pct = 64;
		snk_idle_pct = 23;
		queue_random_traffic(200);
		set_phase_len(16'd1);
		queue_random_traffic(250);

		// No idling; a long receiver hold-off fills the block and stalls input.
		settle();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		queue_random_traffic(250);
		hold_req_cnt++;

		// A long phase length, with one stop condition, then back to one tick.
		set_phase_len(16'd37);
		queue_command(ACT_STOP, 8'h00, 8'h00, 2, 0);
		set_phase_len(16'd1);
		queue_command(ACT_START, 8'h00, 8'h01, 0, 0);
		queue_command(ACT_STOP, 8'h00, 8'h00, 0, 0);

		// Drain, let the last result through, then report.
		while (tick_q.size() != 0 || s_tvalid || bus_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		n_bad += bus_status_q.size();
		$display("tb: %0d ticks accepted, %0d results checked, %0d commands completed",
			n_accepted, n_checked, n_done);
		$display("tb: phase lengths 0, 1, 2, 3 and 37 with stalls on both sides");
		if (n_bad == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
